// ----- hw/rtl/nbmt_pkg.sv -----
// ----------------------------------------------------------------------------
// nbmt_pkg
// Types, codes and helpers shared by the netblock membership table.
// ----------------------------------------------------------------------------
package nbmt_pkg;

  localparam int unsigned ADDR_W   = 128;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned V4_W     = 32;
  localparam int unsigned PREFIX_W = 8;

  localparam logic [PREFIX_W-1:0] V4_PREFIX_MAX = 8'd32;
  localparam logic [PREFIX_W-1:0] V6_PREFIX_MAX = 8'd128;

  // 127.0.0.0/8 and ::1
  localparam logic [7:0]        LOCALHOST_V4_NET = 8'h7F;
  localparam logic [ADDR_W-1:0] LOCALHOST_V6     = 128'h1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_DUP  = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  // network mask for a prefix already clamped to the family limit
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic v6,
                                                    input logic [PREFIX_W-1:0] p);
    logic [V4_W-1:0] m4;
    m4 = ~({V4_W{1'b1}} >> p);
    if (v6) begin
      prefix_mask = ~({ADDR_W{1'b1}} >> p);
    end else begin
      prefix_mask = {{(ADDR_W-V4_W){1'b0}}, m4};
    end
  endfunction

endpackage

// ----- hw/rtl/netblock_membership_table.sv -----
// ----------------------------------------------------------------------------
// netblock_membership_table
// Table of IPv4/IPv6 netblocks with clear, insert and lookup commands.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive operation, is_ipv6, address_high, address_low and
//   prefix_length with start high; the command is taken at a clock edge where
//   start is high and busy is low. busy is rst registered, so it is high during
//   reset and stays high into the cycle after reset ends.
//   Result channel: blocked and status are valid for exactly one cycle while
//   done is high. The receiver cannot stall, so it must sample on done.
//   A taken command is held in the command register; its result is registered
//   into done, blocked and status. Throughput: one command every cycle while
//   busy is low; each command is compared against all MAX_ENTRIES slots in
//   parallel, and the table update lands before the next command is evaluated.
//   Config: cfg_write with cfg_wdata sets localhost_blocked (reset 1); write
//   it only while no command is in flight.
//   Reset (rst, synchronous): empties the table, drops any command in flight
//   and sets localhost blocking on.
// ----------------------------------------------------------------------------
module netblock_membership_table #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic                                 is_ipv6,
  input  logic [nbmt_pkg::HALF_W-1:0]          address_high,
  input  logic [nbmt_pkg::HALF_W-1:0]          address_low,
  input  logic [nbmt_pkg::PREFIX_W-1:0]        prefix_length,
  input  logic                                 cfg_write,
  input  logic                                 cfg_wdata,
  output logic                                 done,
  output logic                                 blocked,
  output logic [1:0]                           status
);
  import nbmt_pkg::*;

  localparam int unsigned IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_ENTRIES);

  // command register
  logic                cmd_valid;
  logic [1:0]          cmd_op;
  logic                cmd_v6;
  logic [ADDR_W-1:0]   cmd_addr;
  logic [PREFIX_W-1:0] cmd_prefix;

  // table
  logic [MAX_ENTRIES-1:0] slot_valid;
  logic                   slot_is_ipv6      [MAX_ENTRIES];
  logic [HALF_W-1:0]      slot_address_high [MAX_ENTRIES];
  logic [HALF_W-1:0]      slot_address_low  [MAX_ENTRIES];
  logic [PREFIX_W-1:0]    slot_prefix       [MAX_ENTRIES];
  logic [COUNT_W-1:0]     slots_used;

  logic localhost_blocked;

  logic [ADDR_W-1:0]      in_addr;
  logic [PREFIX_W-1:0]    in_prefix;
  logic [PREFIX_W-1:0]    prefix_lim;
  logic [ADDR_W-1:0]      ins_addr;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] dup_vec;
  logic                   local_hit;
  logic                   do_clear;
  logic                   do_write;
  logic                   blocked_next;
  status_t                status_next;
  logic                   cmd_hold_busy;

  assign busy = cmd_hold_busy;

  always_ff @(posedge clk) begin
    cmd_hold_busy <= rst;
  end

  // family masking and prefix clamp on the way in
  always_comb begin
    prefix_lim = is_ipv6 ? V6_PREFIX_MAX : V4_PREFIX_MAX;
    in_prefix  = (prefix_length > prefix_lim) ? prefix_lim : prefix_length;
    if (is_ipv6) begin
      in_addr = {address_high, address_low};
    end else begin
      in_addr = {{(ADDR_W-V4_W){1'b0}}, address_low[V4_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
    if (start && !busy) begin
      cmd_op     <= operation;
      cmd_v6     <= is_ipv6;
      cmd_addr   <= in_addr;
      cmd_prefix <= in_prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      localhost_blocked <= 1'b1;
    end else if (cfg_write) begin
      localhost_blocked <= cfg_wdata;
    end
  end

  // per-slot compare against the current table
  assign ins_addr = cmd_addr & prefix_mask(cmd_v6, cmd_prefix);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = slot_valid[i] && (slot_is_ipv6[i] == cmd_v6) &&
                   ((cmd_addr & prefix_mask(cmd_v6, slot_prefix[i])) ==
                    {slot_address_high[i], slot_address_low[i]});
      dup_vec[i] = slot_valid[i] && (slot_is_ipv6[i] == cmd_v6) &&
                   (slot_prefix[i] == cmd_prefix) &&
                   (ins_addr == {slot_address_high[i], slot_address_low[i]});
    end
  end

  always_comb begin
    if (cmd_v6) begin
      local_hit = (cmd_addr == LOCALHOST_V6);
    end else begin
      local_hit = (cmd_addr[V4_W-1:V4_W-8] == LOCALHOST_V4_NET);
    end
  end

  always_comb begin
    do_clear     = 1'b0;
    do_write     = 1'b0;
    blocked_next = 1'b0;
    status_next  = STATUS_OK;
    unique case (cmd_op)
      OP_CLEAR: begin
        do_clear = cmd_valid;
      end
      OP_INSERT: begin
        priority if (|dup_vec) begin
          status_next = STATUS_DUP;
        end else if (slots_used == COUNT_FULL) begin
          status_next = STATUS_FULL;
        end else begin
          do_write = cmd_valid;
        end
      end
      OP_LOOKUP: begin
        blocked_next = (localhost_blocked && local_hit) || (|hit_vec);
      end
      default: begin
        // unused code: no table change, zero result
        blocked_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slots_used <= '0;
    end else if (do_clear) begin
      slot_valid <= '0;
      slots_used <= '0;
    end else if (do_write) begin
      slot_valid[slots_used[IDX_W-1:0]] <= 1'b1;
      slots_used                        <= slots_used + COUNT_W'(1);
    end
  end

  // slot payload needs no reset, unread until its valid bit is set
  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_is_ipv6[slots_used[IDX_W-1:0]]      <= cmd_v6;
      slot_address_high[slots_used[IDX_W-1:0]] <= ins_addr[ADDR_W-1:HALF_W];
      slot_address_low[slots_used[IDX_W-1:0]]  <= ins_addr[HALF_W-1:0];
      slot_prefix[slots_used[IDX_W-1:0]]       <= cmd_prefix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd_valid;
    end
    blocked <= blocked_next;
    status  <= status_next;
  end

endmodule

// ----- tb/netblock_membership_table_tb.sv -----
// ----------------------------------------------------------------------------
// netblock_membership_table_tb
// Drives clear, insert and lookup commands into the netblock table and checks
// every result against a behavioral copy of the table kept in the testbench.
// Covers prefix masking and clamping, duplicates, a full table, family
// separation and the localhost blocking switch, under random sender gaps.
// ----------------------------------------------------------------------------
module netblock_membership_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nbmt_pkg::*;

  localparam int MAX_ENTRIES = 32;
  localparam int TIMEOUT_NS  = 5_000_000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic    blocked;
    status_t status;
  } verdict_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic        is_ipv6;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [7:0]  prefix_length;
  logic        cfg_write;
  logic        cfg_wdata;
  logic        done;
  logic        blocked;
  logic [1:0]  status;

  // shadow copy of the netblock store
  bit           shadow_valid [MAX_ENTRIES];
  logic         shadow_v6    [MAX_ENTRIES];
  logic [127:0] shadow_net   [MAX_ENTRIES];
  logic [7:0]   shadow_plen  [MAX_ENTRIES];
  int           shadow_used;
  logic         localhost_on;

  verdict_t pending_verdicts[$];
  int       error_count;
  int       idle_pct;

  netblock_membership_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .is_ipv6      (is_ipv6),
    .address_high (address_high),
    .address_low  (address_low),
    .prefix_length(prefix_length),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .blocked      (blocked),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic int clamp_plen(logic v6, logic [7:0] plen);
    int lim;
    lim = v6 ? 128 : 32;
    return (int'(plen) > lim) ? lim : int'(plen);
  endfunction

  function automatic logic [127:0] net_mask(logic v6, int p);
    logic [31:0] m4;
    if (p == 0) return '0;
    if (v6) return {128{1'b1}} << (128 - p);
    m4 = 32'hFFFF_FFFF << (32 - p);
    return {96'b0, m4};
  endfunction

  // random address inside stored block i; host bits and unused v4 bits random
  function automatic logic [127:0] inside_addr(int i);
    logic [127:0] m;
    m = net_mask(shadow_v6[i], int'(shadow_plen[i]));
    return shadow_net[i] | (rand128() & ~m);
  endfunction

  function automatic verdict_t predict_verdict(logic [1:0] op, logic v6, logic [63:0] ah,
                                               logic [63:0] al, logic [7:0] plen);
    verdict_t     v;
    logic [127:0] a;
    logic [127:0] m;
    int           p;
    logic         dup;
    v.blocked = 1'b0;
    v.status  = STATUS_OK;
    a = v6 ? {ah, al} : {96'b0, al[31:0]};
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < MAX_ENTRIES; i++) shadow_valid[i] = 1'b0;
        shadow_used = 0;
      end
      OP_INSERT: begin
        p = clamp_plen(v6, plen);
        m = net_mask(v6, p);
        a = a & m;
        dup = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_v6[i] == v6 && shadow_plen[i] == p &&
              shadow_net[i] == a) dup = 1'b1;
        end
        if (dup) begin
          v.status = STATUS_DUP;
        end else if (shadow_used >= MAX_ENTRIES) begin
          v.status = STATUS_FULL;
        end else begin
          shadow_valid[shadow_used] = 1'b1;
          shadow_v6[shadow_used]    = v6;
          shadow_net[shadow_used]   = a;
          shadow_plen[shadow_used]  = p[7:0];
          shadow_used++;
        end
      end
      OP_LOOKUP: begin
        if (localhost_on) begin
          if (v6) v.blocked = (a == 128'h1);
          else v.blocked = (a[31:24] == 8'h7F);
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_v6[i] == v6 &&
              (a & net_mask(v6, int'(shadow_plen[i]))) == shadow_net[i]) v.blocked = 1'b1;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_cmd(input logic [1:0] op, input logic v6, input logic [63:0] ah,
                          input logic [63:0] al, input logic [7:0] plen);
    start         <= 1'b1;
    operation     <= op;
    is_ipv6       <= v6;
    address_high  <= ah;
    address_low   <= al;
    prefix_length <= plen;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(predict_verdict(op, v6, ah, al, plen));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // v4 commands carry garbage in the ignored address bits
  task automatic send_v4(input logic [1:0] op, input logic [31:0] a, input logic [7:0] plen);
    send_cmd(op, 1'b0, {$urandom, $urandom}, {$urandom, a}, plen);
  endtask

  task automatic send_v6(input logic [1:0] op, input logic [127:0] a, input logic [7:0] plen);
    send_cmd(op, 1'b1, a[127:64], a[63:0], plen);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_localhost(input logic v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    localhost_on = v;
    cfg_write <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_v4(OP_LOOKUP, 32'h7F00_0001, 8'd0);
    send_v6(OP_LOOKUP, 128'h1, 8'd0);
    send_v6(OP_LOOKUP, 128'h2, 8'd0);
    send_v4(OP_LOOKUP, 32'h8000_0000, 8'd0);
    send_v4(OP_INSERT, 32'h0A01_0203, 8'd8);
    send_v4(OP_INSERT, 32'h0AC8_0000, 8'd8);
    send_v4(OP_INSERT, 32'hC0A8_014D, 8'd255);
    send_v4(OP_INSERT, 32'hC0A8_014D, 8'd32);
    send_v6(OP_INSERT, 128'h2001_0db8_1234_5678_9abc_def0_1111_2222, 8'd32);
    send_v6(OP_INSERT, '1, 8'd200);
    send_v6(OP_INSERT, '1, 8'd128);
    send_v6(OP_INSERT, 128'hfedc_ba98_7654_3210_ffff_0000_ffff_0000, 8'd65);
    send_v4(OP_INSERT, 32'h7F12_3456, 8'd8);
    send_v4(OP_LOOKUP, 32'h0A63_0101, 8'd0);
    send_v4(OP_LOOKUP, 32'hC0A8_014E, 8'd0);
    send_v6(OP_LOOKUP, 128'h2001_0db8_ffff_0000_0000_0000_0000_0000, 8'd0);
    send_v6(OP_LOOKUP, '1, 8'd0);
    // prefix 65 reaches one bit into the low half
    send_v6(OP_LOOKUP, 128'hfedc_ba98_7654_3210_7fff_ffff_ffff_ffff, 8'd0);
    send_v6(OP_LOOKUP, 128'hfedc_ba98_7654_3210_8000_0000_1234_5678, 8'd0);
    send_cmd(OP_UNUSED, 1'b1, '1, '1, '1);
    send_v6(OP_LOOKUP, 128'h0A00_0001, 8'd0);
    send_v4(OP_CLEAR, 32'h0, 8'd0);
    send_v4(OP_LOOKUP, 32'h0A01_0101, 8'd0);
    send_v4(OP_INSERT, $urandom, 8'd0);
    send_v4(OP_LOOKUP, $urandom, 8'd0);
    send_v6(OP_INSERT, rand128(), 8'd0);
    send_v6(OP_LOOKUP, rand128(), 8'd0);
    send_v4(OP_CLEAR, 32'h0, 8'd0);
  endtask

  // fill every slot, overflow it, then hit duplicates on the full store
  task automatic test_table_capacity();
    logic         v6;
    logic [127:0] a;
    int           i;
    send_cmd(OP_CLEAR, 1'b0, '0, '0, '0);
    repeat (MAX_ENTRIES + 6) begin
      v6 = 1'($urandom_range(1));
      a  = rand128();
      send_cmd(OP_INSERT, v6, a[127:64], a[63:0], 8'($urandom_range(v6 ? 128 : 32, 8)));
    end
    repeat (4) begin
      i = $urandom_range(shadow_used - 1);
      a = inside_addr(i);
      send_cmd(OP_INSERT, shadow_v6[i], a[127:64], a[63:0], shadow_plen[i]);
    end
    repeat (8) begin
      i = $urandom_range(shadow_used - 1);
      a = inside_addr(i);
      send_cmd(OP_LOOKUP, shadow_v6[i], a[127:64], a[63:0], 8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic(input int n);
    int           r;
    int           i;
    int           bitpos;
    logic         v6;
    logic [127:0] a;
    logic [7:0]   plen;
    repeat (n) begin
      r  = $urandom_range(99);
      v6 = 1'($urandom_range(1));
      a  = rand128();
      plen = 8'($urandom_range(255));
      if (r < 2) begin
        send_cmd(OP_CLEAR, v6, a[127:64], a[63:0], plen);
      end else if (r < 6) begin
        send_cmd(OP_UNUSED, v6, a[127:64], a[63:0], plen);
      end else if (r < 46) begin
        if (shadow_used > 0 && $urandom_range(3) == 0) begin
          // same block again, other host bits, maybe an overlong alias
          i  = $urandom_range(shadow_used - 1);
          v6 = shadow_v6[i];
          a  = inside_addr(i);
          plen = shadow_plen[i];
          if (plen == (v6 ? 8'd128 : 8'd32) && $urandom_range(1))
            plen = 8'($urandom_range(255, plen));
        end else if ($urandom_range(9) != 0) begin
          plen = 8'($urandom_range(v6 ? 128 : 32, 8));
        end
        send_cmd(OP_INSERT, v6, a[127:64], a[63:0], plen);
      end else begin
        r = $urandom_range(99);
        if (shadow_used > 0 && r < 65) begin
          i  = $urandom_range(shadow_used - 1);
          v6 = shadow_v6[i];
          a  = inside_addr(i);
          // near miss: flip one network bit
          if (r >= 50 && shadow_plen[i] != 0) begin
            bitpos = (v6 ? 127 : 31) - $urandom_range(shadow_plen[i] - 1);
            a[bitpos] = ~a[bitpos];
          end
        end else if (r < 80) begin
          if (v6) a = 128'h1;
          else a[31:24] = 8'h7F;
        end
        send_cmd(OP_LOOKUP, v6, a[127:64], a[63:0], plen);
      end
    end
  endtask

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with no transaction outstanding: blocked %0d status %0d",
               blocked, status);
        error_count++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (blocked !== exp_v.blocked) begin
          $error("blocked: expected %0d, got %0d", exp_v.blocked, blocked);
          error_count++;
        end
        if (status !== exp_v.status) begin
          $error("status: expected %0d, got %0d", exp_v.status, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count   = 0;
    shadow_used   = 0;
    localhost_on  = 1'b1;
    idle_pct      = 36;
    rst           <= 1'b1;
    start         <= 1'b0;
    operation     <= OP_CLEAR;
    is_ipv6       <= 1'b0;
    address_high  <= '0;
    address_low   <= '0;
    prefix_length <= '0;
    cfg_write     <= 1'b0;
    cfg_wdata     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    set_localhost(1'b0);
    test_table_capacity();
    test_random_traffic(120);
    set_localhost(1'b1);
    idle_pct = 86;
    test_random_traffic(120);
    set_localhost(1'b0);
    idle_pct = 0;
    test_random_traffic(120);
    set_localhost(1'b1);
    test_random_traffic(20);

    wait_drained();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
